FILE: sv/tfbms_pkg.sv
package tfbms_pkg;

  localparam int TABU_DEPTH_DEF = 64;
  localparam int HASH_W         = 64;
  localparam int HEIGHT_W       = 32;
  localparam int LEN_W          = 6;
  localparam int APB_DW         = 32;
  localparam int APB_AW         = 3;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(8);

  localparam logic REG_KEEP_LEN    = 1'b0;
  localparam logic REG_SEED_INSERT = 1'b1;

  typedef enum logic [1:0] {
    OP_START    = 2'd0,
    OP_NEIGHBOR = 2'd1,
    OP_END      = 2'd2
  } op_t;

endpackage

FILE: sv/tabu_filtered_best_move_selector_core.sv
// channel   signals                                   transaction at
// --------  ----------------------------------------  ---------------------------
// item in   start busy opcode move_hash move_height    start && !busy
// result    done is_tabu candidate_taken chosen_hash   done (one cycle, no stall)
//           chosen_height new_best best_level
// config    psel penable pwrite paddr pwdata prdata    psel && penable && pwrite
//           pready                                    (pready tied high)
//
// start, unused opcode: done from S_EXEC; end: S_EXEC then S_TRIM, which trims the ring
// neighbour: S_EXEC then S_SCAN, where one memory read port and one 64-bit comparator
//   walk the ring from head over count entries, stopping early on a hit
// synchronous active-high reset; ring contents are not cleared, only head and count
// busy is high from accept until done; results cannot be stalled
module tabu_filtered_best_move_selector_core
  import tfbms_pkg::*;
#(
  parameter int TABU_DEPTH = TABU_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          opcode,
  input  logic [HASH_W-1:0]   move_hash,
  input  logic [HEIGHT_W-1:0] move_height,
  output logic                done,
  output logic                is_tabu,
  output logic                candidate_taken,
  output logic [HASH_W-1:0]   chosen_hash,
  output logic [HEIGHT_W-1:0] chosen_height,
  output logic                new_best,
  output logic [HEIGHT_W-1:0] best_level,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  localparam int AW   = $clog2(TABU_DEPTH);
  localparam int CW   = $clog2(TABU_DEPTH + 1);
  localparam int SW   = AW + 1;
  localparam int CMPW = (CW > LEN_W) ? CW : LEN_W;
  localparam int TW   = (CMPW > SW) ? CMPW : SW;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_TRIM = 4'b1000
  } state_t;

  state_t              state;
  logic [1:0]          op_q;
  logic [HASH_W-1:0]   hash_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [AW-1:0]       head;
  logic [CW-1:0]       count;
  logic                cand_valid;
  logic [HASH_W-1:0]   cand_hash;
  logic [HEIGHT_W-1:0] cand_height;
  logic [HEIGHT_W-1:0] best_cost;
  logic [LEN_W-1:0]    list_len;
  logic                seed_insert;
  logic [AW-1:0]       scan_ptr;
  logic [CW-1:0]       issued;
  logic                cmp_valid;
  logic                hit;

  logic                ring_we;
  logic [AW-1:0]       ring_waddr;
  logic [HASH_W-1:0]   ring_wdata;
  logic [HASH_W-1:0]   ring_rdata;
  logic [SW-1:0]       push_sum;
  logic                ring_full;
  logic [AW-1:0]       head_inc;
  logic [AW-1:0]       scan_ptr_inc;
  logic                over_len;
  logic [TW-1:0]       trim_sum;
  logic [TW-1:0]       trim_wrap;
  logic                cfg_write;

  assign busy   = (state != S_IDLE);
  assign pready = 1'b1;

  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    case (paddr[2])
      REG_KEEP_LEN:    prdata = APB_DW'(list_len);
      REG_SEED_INSERT: prdata = APB_DW'(seed_insert);
      default:         prdata = '0;
    endcase
  end

  // ring pointer arithmetic
  assign ring_full    = (count == CW'(TABU_DEPTH));
  assign push_sum     = SW'(head) + SW'(count);
  assign ring_waddr   = (push_sum >= SW'(TABU_DEPTH)) ? AW'(push_sum - SW'(TABU_DEPTH))
                                                      : AW'(push_sum);
  assign head_inc     = (head == AW'(TABU_DEPTH - 1)) ? '0 : head + AW'(1);
  assign scan_ptr_inc = (scan_ptr == AW'(TABU_DEPTH - 1)) ? '0 : scan_ptr + AW'(1);
  assign over_len     = (CMPW'(count) > CMPW'(list_len));
  assign trim_sum     = TW'(head) + TW'(count) - TW'(list_len);
  assign trim_wrap    = (trim_sum >= TW'(TABU_DEPTH)) ? trim_sum - TW'(TABU_DEPTH) : trim_sum;

  assign ring_we    = (state == S_EXEC) &&
                      (((op_q == OP_START) && seed_insert) || ((op_q == OP_END) && cand_valid));
  assign ring_wdata = (op_q == OP_START) ? hash_q : cand_hash;

  tfbms_ring #(
    .DEPTH (TABU_DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .raddr (scan_ptr),
    .rdata (ring_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head        <= '0;
      count       <= '0;
      cand_valid  <= 1'b0;
      cand_hash   <= '0;
      cand_height <= '1;
      best_cost   <= '1;
      done        <= 1'b0;
      list_len    <= LEN_RESET;
      seed_insert <= 1'b0;
      cmp_valid   <= 1'b0;
      hit         <= 1'b0;
    end else begin
      done <= 1'b0;

      if (cfg_write) begin
        case (paddr[2])
          REG_KEEP_LEN:    list_len <= pwdata[LEN_W-1:0];
          REG_SEED_INSERT: seed_insert <= pwdata[0];
          default: ;
        endcase
      end

      if (ring_we) begin
        if (ring_full) begin
          head <= head_inc;
        end else begin
          count <= count + CW'(1);
        end
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            op_q     <= opcode;
            hash_q   <= move_hash;
            height_q <= move_height;
            state    <= S_EXEC;
          end
        end

        S_EXEC: begin
          is_tabu         <= 1'b0;
          candidate_taken <= 1'b0;
          new_best        <= 1'b0;
          case (op_q)
            OP_START: begin
              best_cost     <= height_q;
              best_level    <= height_q;
              cand_valid    <= 1'b0;
              cand_hash     <= '0;
              cand_height   <= '1;
              chosen_hash   <= '0;
              chosen_height <= '1;
              done          <= 1'b1;
              state         <= S_IDLE;
            end
            OP_NEIGHBOR: begin
              scan_ptr  <= head;
              issued    <= '0;
              cmp_valid <= 1'b0;
              hit       <= 1'b0;
              state     <= S_SCAN;
            end
            OP_END: begin
              chosen_hash     <= cand_hash;
              chosen_height   <= cand_height;
              candidate_taken <= cand_valid;
              if (cand_valid && (cand_height < best_cost)) begin
                best_cost  <= cand_height;
                best_level <= cand_height;
                new_best   <= 1'b1;
              end else begin
                best_level <= best_cost;
              end
              cand_valid  <= 1'b0;
              cand_hash   <= '0;
              cand_height <= '1;
              state       <= S_TRIM;
            end
            default: begin
              chosen_hash   <= cand_hash;
              chosen_height <= cand_height;
              best_level    <= best_cost;
              done          <= 1'b1;
              state         <= S_IDLE;
            end
          endcase
        end

        S_SCAN: begin
          if ((issued != count) && !hit) begin
            scan_ptr  <= scan_ptr_inc;
            issued    <= issued + CW'(1);
            cmp_valid <= 1'b1;
          end else begin
            cmp_valid <= 1'b0;
          end
          if (cmp_valid && (ring_rdata == hash_q)) begin
            hit <= 1'b1;
          end
          if (!cmp_valid && ((issued == count) || hit)) begin
            is_tabu    <= hit;
            best_level <= best_cost;
            if (!hit && (!cand_valid || (height_q < cand_height))) begin
              cand_valid    <= 1'b1;
              cand_hash     <= hash_q;
              cand_height   <= height_q;
              chosen_hash   <= hash_q;
              chosen_height <= height_q;
            end else begin
              chosen_hash   <= cand_hash;
              chosen_height <= cand_height;
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end

        S_TRIM: begin
          if (over_len) begin
            head  <= AW'(trim_wrap);
            count <= CW'(list_len);
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CW'(count) <= CW'(TABU_DEPTH))
    else $error("ring count beyond depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_end_trimmed: assert property (@(posedge clk) disable iff (rst)
    (done && (op_q == OP_END)) |-> (CMPW'(count) <= CMPW'(list_len)))
    else $error("ring longer than list length after end");

  a_tabu_neighbour: assert property (@(posedge clk) disable iff (rst)
    (done && is_tabu) |-> ((op_q == OP_NEIGHBOR) && !$past(cmp_valid) && hit))
    else $error("tabu flag without a completed hit");
`endif

endmodule

FILE: sv/tfbms_ring.sv
module tfbms_ring
  import tfbms_pkg::*;
#(
  parameter int DEPTH = TABU_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [HASH_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [HASH_W-1:0] rdata
);

  logic [HASH_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import tfbms_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 3000;

  typedef struct packed {
    logic                is_tabu;
    logic                candidate_taken;
    logic [HASH_W-1:0]   chosen_hash;
    logic [HEIGHT_W-1:0] chosen_height;
    logic                new_best;
    logic [HEIGHT_W-1:0] best_level;
  } move_verdict_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          opcode = '0;
  logic [HASH_W-1:0]   move_hash = '0;
  logic [HEIGHT_W-1:0] move_height = '0;
  logic                done;
  logic                is_tabu;
  logic                candidate_taken;
  logic [HASH_W-1:0]   chosen_hash;
  logic [HEIGHT_W-1:0] chosen_height;
  logic                new_best;
  logic [HEIGHT_W-1:0] best_level;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  tabu_filtered_best_move_selector_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .move_hash(move_hash), .move_height(move_height), .done(done),
    .is_tabu(is_tabu), .candidate_taken(candidate_taken),
    .chosen_hash(chosen_hash), .chosen_height(chosen_height),
    .new_best(new_best), .best_level(best_level),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic [HASH_W-1:0]   tabu_fifo[$];
  logic                cand_valid = 1'b0;
  logic [HASH_W-1:0]   cand_hash = '0;
  logic [HEIGHT_W-1:0] cand_height = '1;
  logic [HEIGHT_W-1:0] best_cost = '1;
  logic [LEN_W-1:0]    keep_len = LEN_RESET;
  logic                seed_on = 1'b0;

  move_verdict_t       pending_verdicts[$];
  logic [HASH_W-1:0]   hash_pool[16];
  bit                  idle_on = 1'b1;
  int                  errors = 0;
  int                  n_items = 0;
  int                  n_results = 0;
  int                  n_tabu_hits = 0;
  int                  n_commits = 0;
  int                  n_improved = 0;
  int                  n_ring_drops = 0;
  int                  stall_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void push_tabu(logic [HASH_W-1:0] h);
    if (tabu_fifo.size() >= TABU_DEPTH_DEF) begin
      tabu_fifo.delete(0);
      n_ring_drops++;
    end
    tabu_fifo = {tabu_fifo, h};
  endfunction

  function automatic move_verdict_t select_move(logic [1:0] opc, logic [HASH_W-1:0] h,
                                                logic [HEIGHT_W-1:0] ht);
    move_verdict_t r;
    bit            listed;
    r = '0;
    r.chosen_hash = cand_hash;
    r.chosen_height = cand_height;
    case (opc)
      OP_START: begin
        best_cost = ht;
        cand_valid = 1'b0;
        cand_hash = '0;
        cand_height = '1;
        if (seed_on) push_tabu(h);
        r.chosen_hash = cand_hash;
        r.chosen_height = cand_height;
      end
      OP_NEIGHBOR: begin
        listed = 1'b0;
        foreach (tabu_fifo[i]) if (tabu_fifo[i] == h) listed = 1'b1;
        if (listed) begin
          r.is_tabu = 1'b1;
          n_tabu_hits++;
        end else if (!cand_valid || ht < cand_height) begin
          cand_valid = 1'b1;
          cand_hash = h;
          cand_height = ht;
        end
        r.chosen_hash = cand_hash;
        r.chosen_height = cand_height;
      end
      OP_END: begin
        if (cand_valid) begin
          r.candidate_taken = 1'b1;
          n_commits++;
          if (cand_height < best_cost) begin
            best_cost = cand_height;
            r.new_best = 1'b1;
            n_improved++;
          end
          push_tabu(cand_hash);
        end
        while (tabu_fifo.size() > int'(keep_len)) tabu_fifo.delete(0);
        cand_valid = 1'b0;
        cand_hash = '0;
        cand_height = '1;
      end
      default: ;
    endcase
    r.best_level = best_cost;
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    move_verdict_t want;
    if (!rst && done) begin
      n_results++;
      if (pending_verdicts.size() == 0) begin
        flag_mismatch("unexpected transaction", chosen_hash, '0);
      end else begin
        want = pending_verdicts[0];
        pending_verdicts.delete(0);
        if (is_tabu !== want.is_tabu)
          flag_mismatch("is_tabu", 64'(is_tabu), 64'(want.is_tabu));
        if (candidate_taken !== want.candidate_taken)
          flag_mismatch("candidate_taken", 64'(candidate_taken),
                        64'(want.candidate_taken));
        if (chosen_hash !== want.chosen_hash)
          flag_mismatch("chosen_hash", chosen_hash, want.chosen_hash);
        if (chosen_height !== want.chosen_height)
          flag_mismatch("chosen_height", 64'(chosen_height), 64'(want.chosen_height));
        if (new_best !== want.new_best)
          flag_mismatch("new_best", 64'(new_best), 64'(want.new_best));
        if (best_level !== want.best_level)
          flag_mismatch("best_level", 64'(best_level), 64'(want.best_level));
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tabu_filtered_best_move_selector_core verification failed");
        $finish;
      end
    end
  end

  task automatic send_item(logic [1:0] opc, logic [HASH_W-1:0] h, logic [HEIGHT_W-1:0] ht);
    int            gap;
    move_verdict_t v;
    @(posedge clk);
    if (idle_on && $urandom_range(0, 99) < 21) begin
      while (busy) @(posedge clk);
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    opcode <= opc;
    move_hash <= h;
    move_height <= ht;
    do @(posedge clk); while (!(start && !busy));
    v = select_move(opc, h, ht);
    pending_verdicts = {pending_verdicts, v};
    n_items++;
    start <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic set_reg(logic idx, logic [APB_DW-1:0] val);
    logic [APB_DW-1:0] want;
    wait_drained();
    while (busy) @(posedge clk);
    repeat (4) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == REG_KEEP_LEN) begin
      keep_len = val[LEN_W-1:0];
      want = APB_DW'(keep_len);
    end else begin
      seed_on = val[0];
      want = APB_DW'(seed_on);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) flag_mismatch("register read-back", 64'(prdata), 64'(want));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [HASH_W-1:0] pick_hash();
    int r;
    int slot;
    r = $urandom_range(0, 9);
    slot = $urandom_range(0, 15);
    if (r < 6) return hash_pool[slot];
    if (r == 6) begin
      hash_pool[slot] = rand64();
      return hash_pool[slot];
    end
    return rand64();
  endfunction

  function automatic logic [HEIGHT_W-1:0] pick_height();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return $urandom;
      default: return HEIGHT_W'($urandom_range(100, 110));
    endcase
  endfunction

  // neighbour, end and unused-opcode items with no start since reset
  task automatic test_before_start();
    send_item(OP_NEIGHBOR, 64'h0123_4567_89ab_cdef, 32'd50);
    send_item(OP_END, '0, '0);
    send_item(OP_UNUSED, '1, '1);
    send_item(OP_NEIGHBOR, 64'h0123_4567_89ab_cdef, 32'd10);
  endtask

  // field extremes, ties, tabu hits and an empty iteration
  task automatic test_extremes();
    send_item(OP_START, '0, '1);
    send_item(OP_NEIGHBOR, '1, '1);
    send_item(OP_NEIGHBOR, 64'h5555_5555_5555_5555, '1);
    send_item(OP_NEIGHBOR, 64'haaaa_aaaa_aaaa_aaaa, '0);
    send_item(OP_NEIGHBOR, 64'h0123_4567_89ab_cdef, '0);
    send_item(OP_NEIGHBOR, 64'hffff_0000_ffff_0000, '0);
    send_item(OP_END, '1, '1);
    send_item(OP_NEIGHBOR, 64'haaaa_aaaa_aaaa_aaaa, 32'd1);
    send_item(OP_UNUSED, 64'haaaa_aaaa_aaaa_aaaa, '0);
    send_item(OP_END, '0, '0);
  endtask

  // seeding on start, short list, list length zero
  task automatic test_seed_and_length();
    set_reg(REG_SEED_INSERT, 32'd1);
    set_reg(REG_KEEP_LEN, 32'd1);
    send_item(OP_START, 64'hdead_beef_0000_0001, 32'd900);
    send_item(OP_NEIGHBOR, 64'hdead_beef_0000_0001, 32'd3);
    send_item(OP_NEIGHBOR, 64'hdead_beef_0000_0002, 32'd3);
    send_item(OP_END, '0, '0);
    send_item(OP_NEIGHBOR, 64'hdead_beef_0000_0001, 32'd5);
    send_item(OP_NEIGHBOR, 64'hdead_beef_0000_0002, 32'd5);
    send_item(OP_START, 64'hdead_beef_0000_0003, 32'd7);
    set_reg(REG_KEEP_LEN, 32'd0);
    send_item(OP_END, '0, '0);
    send_item(OP_NEIGHBOR, 64'hdead_beef_0000_0003, 32'd2);
    set_reg(REG_SEED_INSERT, 32'd0);
    set_reg(REG_KEEP_LEN, 32'd63);
  endtask

  // starts pile up past the ring depth so the oldest entries fall out
  task automatic test_ring_overflow();
    set_reg(REG_SEED_INSERT, 32'd1);
    for (int i = 0; i < 66; i++) send_item(OP_START, 64'h1000 + i, pick_height());
    send_item(OP_NEIGHBOR, 64'h1000, 32'd4);
    send_item(OP_NEIGHBOR, 64'h1002, 32'd2);
    send_item(OP_NEIGHBOR, 64'h1041, 32'd1);
    send_item(OP_END, '0, '0);
    send_item(OP_NEIGHBOR, 64'h1002, 32'd1);
  endtask

  task automatic run_iterations(int n);
    int sent;
    int k;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 49) == 0) wait_drained();
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 3) == 0) begin
          send_item(OP_START, pick_hash(), pick_height());
          sent++;
        end
        k = $urandom_range(1, 8);
        repeat (k) begin
          send_item(OP_NEIGHBOR, pick_hash(), pick_height());
          sent++;
        end
        send_item(OP_END, rand64(), $urandom);
        sent++;
      end else begin
        send_item(2'($urandom_range(0, 3)), rand64(), $urandom);
        sent++;
      end
    end
  endtask

  // well-formed iterations over several settings, with some noise
  task automatic test_random_iterations();
    set_reg(REG_KEEP_LEN, 32'd8);
    set_reg(REG_SEED_INSERT, 32'd0);
    run_iterations(250);
    set_reg(REG_KEEP_LEN, 32'd1);
    set_reg(REG_SEED_INSERT, 32'd1);
    run_iterations(150);
    set_reg(REG_KEEP_LEN, 32'd0);
    set_reg(REG_SEED_INSERT, 32'd0);
    run_iterations(100);
    set_reg(REG_KEEP_LEN, 32'd63);
    set_reg(REG_SEED_INSERT, 32'd1);
    idle_on = 1'b0;
    run_iterations(250);
    idle_on = 1'b1;
    set_reg(REG_KEEP_LEN, {$urandom} & ~32'h20 | 32'h1f);
    set_reg(REG_SEED_INSERT, $urandom);
    run_iterations(100);
    set_reg(REG_KEEP_LEN, $urandom);
    set_reg(REG_SEED_INSERT, $urandom);
    run_iterations(120);
  endtask

  initial begin
    foreach (hash_pool[i]) hash_pool[i] = rand64();
    hash_pool[0] = '0;
    hash_pool[1] = '1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_before_start();
    test_extremes();
    test_seed_and_length();
    test_ring_overflow();
    test_random_iterations();
    wait_drained();
    repeat (80) @(posedge clk);
    $display("covered %0d items, %0d results, %0d tabu hits, %0d commits",
             n_items, n_results, n_tabu_hits, n_commits);
    $display("%0d best-height improvements, %0d entries dropped from a full ring",
             n_improved, n_ring_drops);
    if (errors == 0) begin
      $display("tabu_filtered_best_move_selector_core verification clean");
    end else begin
      $display("tabu_filtered_best_move_selector_core verification failed");
    end
    $finish;
  end

endmodule
